FILE: hw/rtl/npc_pkg.sv
// Shared types and constants for the nearest palette color search block.
package npc_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int COLOR_W           = 24;
  localparam int CHAN_W            = 8;
  localparam int IDX_OUT_W         = 8;
  localparam int CFG_W             = 9;
  localparam int DIST_W            = 18;
  localparam logic [DIST_W-1:0] START_BOUND = DIST_W'(256 * 256 * 3);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                 mode;
    logic [7:0]           entry_index;
    logic [COLOR_W-1:0]   color_value;
  } in_t;

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] nearest_index;
  } out_t;

  typedef struct packed {
    logic vld;
    logic last;
  } pipe_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } npc_state_t;

endpackage

FILE: hw/rtl/npc_palette_mem.sv
// Palette color memory with one write port and one registered read port.
module npc_palette_mem #(
  parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF,
  parameter int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [npc_pkg::COLOR_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [npc_pkg::COLOR_W-1:0] rd_data
);

  logic [npc_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];
  logic [npc_pkg::COLOR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/npc_dist_unit.sv
// Shared squared RGB distance unit: registered channel squares, then the sum.
module npc_dist_unit #(
  parameter int AW = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [npc_pkg::COLOR_W-1:0] q_color,
  input  logic [npc_pkg::COLOR_W-1:0] p_color,
  input  npc_pkg::pipe_ctl_t          in_ctl,
  input  logic [AW-1:0]               in_idx,
  output npc_pkg::pipe_ctl_t          out_ctl,
  output logic [AW-1:0]               out_idx,
  output logic [npc_pkg::DIST_W-1:0]  out_dist
);

  localparam int CW = npc_pkg::CHAN_W;
  localparam int SW = 2 * CW;

  logic [CW-1:0] d_r, d_g, d_b;
  logic [SW-1:0] sq_r_nxt, sq_g_nxt, sq_b_nxt;
  logic [SW-1:0] sq_r_r, sq_g_r, sq_b_r;
  npc_pkg::pipe_ctl_t ctl_r;
  logic [AW-1:0] idx_r;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    d_r = abs_diff(q_color[23:16], p_color[23:16]);
    d_g = abs_diff(q_color[15:8],  p_color[15:8]);
    d_b = abs_diff(q_color[7:0],   p_color[7:0]);
    sq_r_nxt = SW'(d_r) * SW'(d_r);
    sq_g_nxt = SW'(d_g) * SW'(d_g);
    sq_b_nxt = SW'(d_b) * SW'(d_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= in_ctl;
    end
    sq_r_r <= sq_r_nxt;
    sq_g_r <= sq_g_nxt;
    sq_b_r <= sq_b_nxt;
    idx_r  <= in_idx;
  end

  assign out_ctl  = ctl_r;
  assign out_idx  = idx_r;
  assign out_dist = npc_pkg::DIST_W'(sq_r_r) + npc_pkg::DIST_W'(sq_g_r)
                  + npc_pkg::DIST_W'(sq_b_r);

endmodule

FILE: hw/rtl/npc_ctrl.sv
// Search sequencer: write decode, address walk, best-distance tracking, result word.
module npc_ctrl #(
  parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF,
  parameter int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1,
  parameter int CW = $clog2(PALETTE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  npc_pkg::in_t                in_data,
  input  logic [CW-1:0]               cnt,
  output logic                        busy,
  output logic                        wr_en,
  output logic [AW-1:0]               wr_addr,
  output logic [npc_pkg::COLOR_W-1:0] wr_data,
  output logic [AW-1:0]               rd_addr,
  output logic [npc_pkg::COLOR_W-1:0] q_color,
  output npc_pkg::pipe_ctl_t          s1_ctl,
  output logic [AW-1:0]               s1_idx,
  input  npc_pkg::pipe_ctl_t          s2_ctl,
  input  logic [AW-1:0]               s2_idx,
  input  logic [npc_pkg::DIST_W-1:0]  s2_dist,
  output logic                        out_valid,
  output npc_pkg::out_t               out_data
);

  npc_pkg::npc_state_t state_r, state_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic [CW-1:0]               cnt_r, cnt_nxt;
  logic [npc_pkg::COLOR_W-1:0] q_color_r, q_color_nxt;
  npc_pkg::pipe_ctl_t          s1_ctl_r, s1_ctl_nxt;
  logic [AW-1:0]               s1_idx_r;
  logic [npc_pkg::DIST_W-1:0]  best_r, best_nxt;
  logic [AW-1:0]               best_idx_r, best_idx_nxt;
  logic                        out_valid_r, out_valid_nxt;
  npc_pkg::out_t               out_data_r, out_data_nxt;
  logic                        accept;
  logic                        last_issue;
  logic                        upd;

  assign accept     = start && (state_r == npc_pkg::ST_IDLE);
  assign last_issue = (CW'(addr_r) == cnt_r - CW'(1));
  assign upd        = s2_ctl.vld && (s2_dist <= best_r);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    q_color_nxt   = q_color_r;
    s1_ctl_nxt    = '0;
    best_nxt      = best_r;
    best_idx_nxt  = best_idx_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    case (state_r)
      npc_pkg::ST_IDLE: begin
        if (accept && in_data.mode == npc_pkg::MODE_WRITE) begin
          wr_en = (32'(in_data.entry_index) < PALETTE_DEPTH);
        end else if (accept) begin
          q_color_nxt = in_data.color_value;
          cnt_nxt     = cnt;
          addr_nxt    = '0;
          best_nxt    = npc_pkg::START_BOUND;
          best_idx_nxt = '0;
          if (cnt == '0) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
          end else begin
            state_nxt = npc_pkg::ST_RUN;
          end
        end
      end
      npc_pkg::ST_RUN: begin
        s1_ctl_nxt.vld  = 1'b1;
        s1_ctl_nxt.last = last_issue;
        addr_nxt        = addr_r + AW'(1);
        if (last_issue) begin
          state_nxt = npc_pkg::ST_DRAIN;
        end
      end
      npc_pkg::ST_DRAIN: begin
        if (s2_ctl.vld && s2_ctl.last) begin
          state_nxt = npc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = npc_pkg::ST_IDLE;
      end
    endcase
    if (upd) begin
      best_nxt     = s2_dist;
      best_idx_nxt = s2_idx;
    end
    if (s2_ctl.vld && s2_ctl.last) begin
      out_valid_nxt               = 1'b1;
      out_data_nxt.found          = 1'b1;
      out_data_nxt.nearest_index  = npc_pkg::IDX_OUT_W'(upd ? s2_idx : best_idx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npc_pkg::ST_IDLE;
      s1_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      s1_ctl_r    <= s1_ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r     <= addr_nxt;
    cnt_r      <= cnt_nxt;
    q_color_r  <= q_color_nxt;
    s1_idx_r   <= addr_r;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign busy      = (state_r != npc_pkg::ST_IDLE);
  assign wr_addr   = AW'(in_data.entry_index);
  assign wr_data   = in_data.color_value;
  assign rd_addr   = addr_r;
  assign q_color   = q_color_r;
  assign s1_ctl    = s1_ctl_r;
  assign s1_idx    = s1_idx_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: hw/rtl/nearest_palette_color_top.sv
// Nearest palette color search: palette memory, distance unit and search sequencer.
// Write word: busy stays low. Query word: busy while the first N entries are searched,
// N = min(entries_in_use, PALETTE_DEPTH), result strobe in the cycle busy drops; one
// palette entry per cycle through the memory read port. Empty palette: result strobe
// on the cycle after the query. The result is shown for one cycle on out_valid.
// Synchronous reset clears the sequencer and entries_in_use; palette contents are kept.
module nearest_palette_color_top #(
  parameter int PALETTE_DEPTH = npc_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  npc_pkg::in_t              in_data,
  input  logic                      cfg_we,
  input  logic [npc_pkg::CFG_W-1:0] cfg_wdata,
  output logic                      out_valid,
  output npc_pkg::out_t             out_data
);

  localparam int AW   = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW   = $clog2(PALETTE_DEPTH + 1);

  logic [npc_pkg::CFG_W-1:0]   entries_in_use_r;
  logic [CW-1:0]               cnt;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [npc_pkg::COLOR_W-1:0] wr_data;
  logic [AW-1:0]               rd_addr;
  logic [npc_pkg::COLOR_W-1:0] rd_data;
  logic [npc_pkg::COLOR_W-1:0] q_color;
  npc_pkg::pipe_ctl_t          s1_ctl, s2_ctl;
  logic [AW-1:0]               s1_idx, s2_idx;
  logic [npc_pkg::DIST_W-1:0]  s2_dist;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= '0;
    end else if (cfg_we) begin
      entries_in_use_r <= cfg_wdata;
    end
  end

  assign cnt = (32'(entries_in_use_r) > PALETTE_DEPTH) ? CW'(PALETTE_DEPTH)
                                                       : CW'(entries_in_use_r);

  npc_palette_mem #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .AW(AW)
  ) u_mem (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  npc_dist_unit #(
    .AW(AW)
  ) u_dist (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_color (q_color),
    .p_color (rd_data),
    .in_ctl  (s1_ctl),
    .in_idx  (s1_idx),
    .out_ctl (s2_ctl),
    .out_idx (s2_idx),
    .out_dist(s2_dist)
  );

  npc_ctrl #(
    .PALETTE_DEPTH(PALETTE_DEPTH),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_data  (in_data),
    .cnt      (cnt),
    .busy     (busy),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .q_color  (q_color),
    .s1_ctl   (s1_ctl),
    .s1_idx   (s1_idx),
    .s2_ctl   (s2_ctl),
    .s2_idx   (s2_idx),
    .s2_dist  (s2_dist),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
